// ===== hdl/sct_pkg.sv =====
// Shared types and constants for the segment crossing test.
// No dependencies. Used by sct_classify, sct_solve and segment_crossing_test.
package sct_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int TOL_FRAC_BITS_DEF = 16;
    localparam int TOL_WIDTH         = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd66;

    typedef enum logic [2:0] {
        CASE_DISJOINT   = 3'd0,
        CASE_BOTH_VERT  = 3'd1,
        CASE_STEEP      = 3'd2,
        CASE_VERT_HORIZ = 3'd3,
        CASE_BOTH_HORIZ = 3'd4,
        CASE_GENERAL    = 3'd5
    } t_case;

    // control that rides along with an item through the pipe
    typedef struct packed {
        logic  valid;
        t_case kase;
        logic  cross_now;   // verdict for cases that need no solve
        logic  need_solve;  // item needs the line intersection
    } t_cls_ctrl;

endpackage

// ===== hdl/sct_mul_split.sv =====
// Two-stage signed multiplier; the wide operand is cut in two halves.
// Depends on nothing; used by sct_solve.
module sct_mul_split #(
    parameter int NA = 17,
    parameter int NB = 34
) (
    input  logic                    i_clk,
    input  logic signed [NA-1:0]    i_a,
    input  logic signed [NB-1:0]    i_b,
    output logic signed [NA+NB-1:0] o_p
);

    localparam int L  = (NB + 1) / 2;
    localparam int H  = NB - L;
    localparam int PW = NA + NB;

    logic        [L-1:0]    b_lo;
    logic signed [H-1:0]    b_hi;
    logic signed [NA+L:0]   n_lo;
    logic signed [NA+H-1:0] n_hi;
    logic signed [NA+L:0]   r_lo;
    logic signed [NA+H-1:0] r_hi;
    logic signed [PW-1:0]   n_p;
    logic signed [PW-1:0]   r_p;

    assign b_lo = i_b[L-1:0];
    assign b_hi = i_b[NB-1:L];
    assign n_lo = i_a * $signed({1'b0, b_lo});
    assign n_hi = i_a * b_hi;
    assign n_p  = $signed({r_hi, {L{1'b0}}}) + PW'(r_lo);

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_p  <= n_p;
    end

    assign o_p = r_p;

endmodule

// ===== hdl/sct_classify.sv =====
// Front end: box overlap, near-vertical/horizontal tests, case choice, axis select.
// Depends on sct_pkg. Three register stages.
module sct_classify
    import sct_pkg::*;
#(
    parameter int CW  = COORD_WIDTH_DEF,
    parameter int TFB = TOL_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [TOL_WIDTH-1:0] i_tol,
    input  logic signed [CW-1:0] i_ax0,
    input  logic signed [CW-1:0] i_ay0,
    input  logic signed [CW-1:0] i_ax1,
    input  logic signed [CW-1:0] i_ay1,
    input  logic signed [CW-1:0] i_bx0,
    input  logic signed [CW-1:0] i_by0,
    input  logic signed [CW-1:0] i_bx1,
    input  logic signed [CW-1:0] i_by1,
    output t_cls_ctrl            o_ctrl,
    output logic signed [CW-1:0] o_ua0,
    output logic signed [CW-1:0] o_ua1,
    output logic signed [CW-1:0] o_ub0,
    output logic signed [CW-1:0] o_ub1,
    output logic signed [CW:0]   o_dua,
    output logic signed [CW:0]   o_dva,
    output logic signed [CW:0]   o_dub,
    output logic signed [CW:0]   o_dvb,
    output logic signed [CW:0]   o_du0,
    output logic signed [CW:0]   o_dv0
);

    localparam int MW = (TFB > TOL_WIDTH) ? TFB : TOL_WIDTH;
    localparam int KW = CW + MW;
    // axis slots
    localparam int AX = 0;
    localparam int AY = 1;
    localparam int BX = 2;
    localparam int BY = 3;

    function automatic logic signed [CW:0] sdiff(logic signed [CW-1:0] a,
                                                 logic signed [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    // ---- stage 1: extents, magnitudes, box overlap
    logic signed [CW-1:0] c0 [4];
    logic signed [CW-1:0] c1 [4];
    logic signed [CW-1:0] lo [4];
    logic signed [CW-1:0] hi [4];
    logic signed [CW:0]   dif [4];
    logic signed [CW:0]   m0 [4];
    logic signed [CW:0]   m1 [4];
    logic [CW-1:0]        n_s1_ad [4];
    logic [CW-1:0]        n_s1_big [4];
    logic                 n_s1_box;

    assign c0[AX] = i_ax0;
    assign c1[AX] = i_ax1;
    assign c0[AY] = i_ay0;
    assign c1[AY] = i_ay1;
    assign c0[BX] = i_bx0;
    assign c1[BX] = i_bx1;
    assign c0[BY] = i_by0;
    assign c1[BY] = i_by1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            lo[k]  = (c0[k] < c1[k]) ? c0[k] : c1[k];
            hi[k]  = (c0[k] < c1[k]) ? c1[k] : c0[k];
            dif[k] = sdiff(c1[k], c0[k]);
            m0[k]  = c0[k][CW-1] ? -{c0[k][CW-1], c0[k]} : {c0[k][CW-1], c0[k]};
            m1[k]  = c1[k][CW-1] ? -{c1[k][CW-1], c1[k]} : {c1[k][CW-1], c1[k]};
            n_s1_ad[k]  = dif[k][CW] ? CW'(-dif[k]) : CW'(dif[k]);
            n_s1_big[k] = (m0[k] > m1[k]) ? CW'(m0[k]) : CW'(m1[k]);
        end
        n_s1_box = (lo[AX] < hi[BX]) && (lo[BX] < hi[AX]) &&
                   (lo[AY] < hi[BY]) && (lo[BY] < hi[AY]);
    end

    logic                 r_s1_valid;
    logic                 r_s1_box;
    logic signed [CW-1:0] r_s1_c0 [4];
    logic signed [CW-1:0] r_s1_c1 [4];
    logic [CW-1:0]        r_s1_ad [4];
    logic [CW-1:0]        r_s1_big [4];

    // ---- stage 2: both sides of the relative tolerance test
    logic [TOL_WIDTH+CW-1:0] prod [4];
    logic [KW-1:0]           n_s2_lhs [4];
    logic [KW-1:0]           n_s2_rhs [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k]     = i_tol * r_s1_big[k];
            n_s2_lhs[k] = KW'(r_s1_ad[k]) << TFB;
            n_s2_rhs[k] = KW'(prod[k]);
        end
    end

    logic                 r_s2_valid;
    logic                 r_s2_box;
    logic signed [CW-1:0] r_s2_c0 [4];
    logic signed [CW-1:0] r_s2_c1 [4];
    logic [KW-1:0]        r_s2_lhs [4];
    logic [KW-1:0]        r_s2_rhs [4];

    // ---- stage 3: case choice and solve axis select
    logic      av, ah, bv, bh;
    logic      u_y;
    t_cls_ctrl n_ctrl;
    logic signed [CW-1:0] ua0, ua1, va0, va1, ub0, ub1, vb0, vb1;

    always_comb begin
        av = r_s2_lhs[AX] < r_s2_rhs[AX];
        ah = r_s2_lhs[AY] < r_s2_rhs[AY];
        bv = r_s2_lhs[BX] < r_s2_rhs[BX];
        bh = r_s2_lhs[BY] < r_s2_rhs[BY];
        n_ctrl.valid      = r_s2_valid;
        n_ctrl.cross_now  = 1'b0;
        n_ctrl.need_solve = 1'b0;
        if (!r_s2_box) begin
            n_ctrl.kase = CASE_DISJOINT;
        end else if (av || bv) begin
            if (av && bv) begin
                n_ctrl.kase = CASE_BOTH_VERT;
            end else if ((av && !bh) || (bv && !ah)) begin
                n_ctrl.kase       = CASE_STEEP;
                n_ctrl.need_solve = 1'b1;
            end else begin
                n_ctrl.kase      = CASE_VERT_HORIZ;
                n_ctrl.cross_now = 1'b1;
            end
        end else if (ah && bh) begin
            n_ctrl.kase = CASE_BOTH_HORIZ;
        end else begin
            n_ctrl.kase       = CASE_GENERAL;
            n_ctrl.need_solve = 1'b1;
        end
        // steep solve runs on y, general solve on x
        u_y = (n_ctrl.kase == CASE_STEEP);
        ua0 = u_y ? r_s2_c0[AY] : r_s2_c0[AX];
        ua1 = u_y ? r_s2_c1[AY] : r_s2_c1[AX];
        va0 = u_y ? r_s2_c0[AX] : r_s2_c0[AY];
        va1 = u_y ? r_s2_c1[AX] : r_s2_c1[AY];
        ub0 = u_y ? r_s2_c0[BY] : r_s2_c0[BX];
        ub1 = u_y ? r_s2_c1[BY] : r_s2_c1[BX];
        vb0 = u_y ? r_s2_c0[BX] : r_s2_c0[BY];
        vb1 = u_y ? r_s2_c1[BX] : r_s2_c1[BY];
    end

    t_cls_ctrl r_ctrl;
    logic signed [CW-1:0] r_ua0, r_ua1, r_ub0, r_ub1;
    logic signed [CW:0]   r_dua, r_dva, r_dub, r_dvb, r_du0, r_dv0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_ctrl     <= '0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_ctrl     <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_box <= n_s1_box;
        r_s2_box <= r_s1_box;
        for (int k = 0; k < 4; k++) begin
            r_s1_c0[k]  <= c0[k];
            r_s1_c1[k]  <= c1[k];
            r_s1_ad[k]  <= n_s1_ad[k];
            r_s1_big[k] <= n_s1_big[k];
            r_s2_c0[k]  <= r_s1_c0[k];
            r_s2_c1[k]  <= r_s1_c1[k];
            r_s2_lhs[k] <= n_s2_lhs[k];
            r_s2_rhs[k] <= n_s2_rhs[k];
        end
        r_ua0 <= ua0;
        r_ua1 <= ua1;
        r_ub0 <= ub0;
        r_ub1 <= ub1;
        r_dua <= sdiff(ua1, ua0);
        r_dva <= sdiff(va1, va0);
        r_dub <= sdiff(ub1, ub0);
        r_dvb <= sdiff(vb1, vb0);
        r_du0 <= sdiff(ub0, ua0);
        r_dv0 <= sdiff(vb0, va0);
    end

    assign o_ctrl = r_ctrl;
    assign o_ua0  = r_ua0;
    assign o_ua1  = r_ua1;
    assign o_ub0  = r_ub0;
    assign o_ub1  = r_ub1;
    assign o_dua  = r_dua;
    assign o_dva  = r_dva;
    assign o_dub  = r_dub;
    assign o_dvb  = r_dvb;
    assign o_du0  = r_du0;
    assign o_dv0  = r_dv0;

endmodule

// ===== hdl/sct_solve.sv =====
// Back end: exact line intersection and inclusive range check by cross-multiplication.
// Depends on sct_pkg and sct_mul_split. Six register stages, last one drives the result.
module sct_solve
    import sct_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cls_ctrl            i_ctrl,
    input  logic signed [CW-1:0] i_ua0,
    input  logic signed [CW-1:0] i_ua1,
    input  logic signed [CW-1:0] i_ub0,
    input  logic signed [CW-1:0] i_ub1,
    input  logic signed [CW:0]   i_dua,
    input  logic signed [CW:0]   i_dva,
    input  logic signed [CW:0]   i_dub,
    input  logic signed [CW:0]   i_dvb,
    input  logic signed [CW:0]   i_du0,
    input  logic signed [CW:0]   i_dv0,
    output logic                 o_valid,
    output logic                 o_crosses,
    output t_case                o_case
);

    localparam int DW = 2 * CW + 2;     // denominator / numerator
    localparam int PW = CW + DW;        // coordinate times denominator
    localparam int NW = CW + 1 + DW;    // extent times numerator
    localparam int UW = NW + 1;         // scaled intersection coordinate

    // ---- stage 4: cross products
    t_cls_ctrl            r_s4_ctrl;
    logic signed [DW-1:0] r_s4_p1, r_s4_p2, r_s4_p3, r_s4_p4;
    logic signed [CW-1:0] r_s4_ua0, r_s4_ua1, r_s4_ub0, r_s4_ub1;
    logic signed [CW:0]   r_s4_dua;
    logic                 r_s4_duz;

    // ---- stage 5: denominator and numerator
    logic signed [DW-1:0] n_s5_d, n_s5_n;
    t_cls_ctrl            r_s5_ctrl;
    logic signed [DW-1:0] r_s5_d, r_s5_n;
    logic                 r_s5_dz, r_s5_dneg, r_s5_duz;
    logic signed [CW-1:0] r_s5_ua0, r_s5_amin, r_s5_amax, r_s5_bmin, r_s5_bmax;
    logic signed [CW:0]   r_s5_dua;

    assign n_s5_d = r_s4_p1 - r_s4_p2;
    assign n_s5_n = r_s4_p3 - r_s4_p4;

    // ---- stages 6, 7: products against the denominator and the numerator
    logic signed [PW-1:0] m_ua0d, m_amin, m_amax, m_bmin, m_bmax;
    logic signed [NW-1:0] m_duan;
    t_cls_ctrl            r_s6_ctrl, r_s7_ctrl;
    logic                 r_s6_ok, r_s7_ok, r_s6_dneg, r_s7_dneg;

    sct_mul_split #(.NA(CW), .NB(DW)) u_mul_ua0 (
        .i_clk(i_clk), .i_a(r_s5_ua0), .i_b(r_s5_d), .o_p(m_ua0d));
    sct_mul_split #(.NA(CW + 1), .NB(DW)) u_mul_duan (
        .i_clk(i_clk), .i_a(r_s5_dua), .i_b(r_s5_n), .o_p(m_duan));
    sct_mul_split #(.NA(CW), .NB(DW)) u_mul_amin (
        .i_clk(i_clk), .i_a(r_s5_amin), .i_b(r_s5_d), .o_p(m_amin));
    sct_mul_split #(.NA(CW), .NB(DW)) u_mul_amax (
        .i_clk(i_clk), .i_a(r_s5_amax), .i_b(r_s5_d), .o_p(m_amax));
    sct_mul_split #(.NA(CW), .NB(DW)) u_mul_bmin (
        .i_clk(i_clk), .i_a(r_s5_bmin), .i_b(r_s5_d), .o_p(m_bmin));
    sct_mul_split #(.NA(CW), .NB(DW)) u_mul_bmax (
        .i_clk(i_clk), .i_a(r_s5_bmax), .i_b(r_s5_d), .o_p(m_bmax));

    // ---- stage 8: intersection coordinate, scaled by the denominator
    t_cls_ctrl            r_s8_ctrl;
    logic                 r_s8_ok, r_s8_dneg;
    logic signed [UW-1:0] r_s8_un;
    logic signed [PW-1:0] r_s8_amin, r_s8_amax, r_s8_bmin, r_s8_bmax;

    // ---- stage 9: inclusive range checks; a negative denominator swaps the bounds
    logic signed [UW-1:0] lo_a, hi_a, lo_b, hi_b;
    logic                 in_both;
    logic                 n_cross;
    logic                 r_valid, r_cross;
    t_case                r_case;

    always_comb begin
        lo_a    = r_s8_dneg ? UW'(r_s8_amax) : UW'(r_s8_amin);
        hi_a    = r_s8_dneg ? UW'(r_s8_amin) : UW'(r_s8_amax);
        lo_b    = r_s8_dneg ? UW'(r_s8_bmax) : UW'(r_s8_bmin);
        hi_b    = r_s8_dneg ? UW'(r_s8_bmin) : UW'(r_s8_bmax);
        in_both = (lo_a <= r_s8_un) && (r_s8_un <= hi_a) &&
                  (lo_b <= r_s8_un) && (r_s8_un <= hi_b);
        n_cross = r_s8_ctrl.cross_now ||
                  (r_s8_ctrl.need_solve && r_s8_ok && in_both);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctrl <= '0;
            r_s5_ctrl <= '0;
            r_s6_ctrl <= '0;
            r_s7_ctrl <= '0;
            r_s8_ctrl <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_s4_ctrl <= i_ctrl;
            r_s5_ctrl <= r_s4_ctrl;
            r_s6_ctrl <= r_s5_ctrl;
            r_s7_ctrl <= r_s6_ctrl;
            r_s8_ctrl <= r_s7_ctrl;
            r_valid   <= r_s8_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_p1   <= i_dua * i_dvb;
        r_s4_p2   <= i_dva * i_dub;
        r_s4_p3   <= i_du0 * i_dvb;
        r_s4_p4   <= i_dv0 * i_dub;
        r_s4_ua0  <= i_ua0;
        r_s4_ua1  <= i_ua1;
        r_s4_ub0  <= i_ub0;
        r_s4_ub1  <= i_ub1;
        r_s4_dua  <= i_dua;
        r_s4_duz  <= (i_dua == '0) || (i_dub == '0);

        r_s5_d    <= n_s5_d;
        r_s5_n    <= n_s5_n;
        r_s5_dz   <= (n_s5_d == '0);
        r_s5_dneg <= n_s5_d[DW-1];
        r_s5_duz  <= r_s4_duz;
        r_s5_ua0  <= r_s4_ua0;
        r_s5_dua  <= r_s4_dua;
        r_s5_amin <= (r_s4_ua0 < r_s4_ua1) ? r_s4_ua0 : r_s4_ua1;
        r_s5_amax <= (r_s4_ua0 < r_s4_ua1) ? r_s4_ua1 : r_s4_ua0;
        r_s5_bmin <= (r_s4_ub0 < r_s4_ub1) ? r_s4_ub0 : r_s4_ub1;
        r_s5_bmax <= (r_s4_ub0 < r_s4_ub1) ? r_s4_ub1 : r_s4_ub0;

        r_s6_ok   <= !r_s5_dz && !r_s5_duz;
        r_s6_dneg <= r_s5_dneg;
        r_s7_ok   <= r_s6_ok;
        r_s7_dneg <= r_s6_dneg;

        r_s8_ok   <= r_s7_ok;
        r_s8_dneg <= r_s7_dneg;
        r_s8_un   <= UW'(m_ua0d) + UW'(m_duan);
        r_s8_amin <= m_amin;
        r_s8_amax <= m_amax;
        r_s8_bmin <= m_bmin;
        r_s8_bmax <= m_bmax;

        r_cross <= n_cross;
        r_case  <= r_s8_ctrl.kase;
    end

    assign o_valid   = r_valid;
    assign o_crosses = r_cross;
    assign o_case    = r_case;

endmodule

// ===== hdl/segment_crossing_test.sv =====
// Top level of the segment crossing test: tolerance register and the two pipeline halves.
// Depends on sct_pkg, sct_classify, sct_solve (and sct_mul_split below it).
//
// Fully pipelined: one item may be started on every clock and busy never rises.
// Each item gives exactly one result, shown on o_crosses / o_case_taken for one
// cycle with o_valid high, after nine register stages, the first loaded at the
// edge that took start. Three stages classify the pair (box overlap,
// tolerance products, case choice), then six stages solve the line
// intersection (cross products, denominator, a two-stage split multiplier per
// bound, the scaled coordinate, the range compare). Results leave in the order
// items came in; the receiver cannot stall, so nothing is held back. The
// tolerance register is read live by the classify stages, so write it only
// while no item is in flight. Endpoints are signed with 4 fraction bits.
module segment_crossing_test
    import sct_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int TOL_FRAC_BITS = TOL_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [TOL_WIDTH-1:0]          i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_x0,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_y0,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_x1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_y1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_x0,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_y0,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_x1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_y1,
    output logic                          o_valid,
    output logic                          o_crosses,
    output logic [2:0]                    o_case_taken
);

    logic [TOL_WIDTH-1:0] r_tol;
    logic                 item_in;
    t_cls_ctrl            cls_ctrl;
    t_case                res_case;

    logic signed [COORD_WIDTH-1:0] ua0, ua1, ub0, ub1;
    logic signed [COORD_WIDTH:0]   dua, dva, dub, dvb, du0, dv0;

    // no back-pressure anywhere in the pipe
    assign busy    = 1'b0;
    assign item_in = start && !busy;

    // relative tolerance, in units of 2^-TOL_FRAC_BITS
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    sct_classify #(
        .CW (COORD_WIDTH),
        .TFB(TOL_FRAC_BITS)
    ) u_classify (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(item_in),
        .i_tol  (r_tol),
        .i_ax0  (i_seg_a_x0),
        .i_ay0  (i_seg_a_y0),
        .i_ax1  (i_seg_a_x1),
        .i_ay1  (i_seg_a_y1),
        .i_bx0  (i_seg_b_x0),
        .i_by0  (i_seg_b_y0),
        .i_bx1  (i_seg_b_x1),
        .i_by1  (i_seg_b_y1),
        .o_ctrl (cls_ctrl),
        .o_ua0  (ua0),
        .o_ua1  (ua1),
        .o_ub0  (ub0),
        .o_ub1  (ub1),
        .o_dua  (dua),
        .o_dva  (dva),
        .o_dub  (dub),
        .o_dvb  (dvb),
        .o_du0  (du0),
        .o_dv0  (dv0)
    );

    sct_solve #(
        .CW(COORD_WIDTH)
    ) u_solve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (cls_ctrl),
        .i_ua0    (ua0),
        .i_ua1    (ua1),
        .i_ub0    (ub0),
        .i_ub1    (ub1),
        .i_dua    (dua),
        .i_dva    (dva),
        .i_dub    (dub),
        .i_dvb    (dvb),
        .i_du0    (du0),
        .i_dv0    (dv0),
        .o_valid  (o_valid),
        .o_crosses(o_crosses),
        .o_case   (res_case)
    );

    assign o_case_taken = res_case;

endmodule
